// ----- rtl/core/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

  // default queue depth
  localparam int unsigned DEFAULT_CAPACITY = 64;

  localparam int unsigned TAG_W   = 16;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned TOTAL_W = 37;
  localparam int unsigned SUM_W   = 38;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e               opcode;
    logic [TAG_W-1:0]  entry_tag;
    logic [SIZE_W-1:0] entry_size;
    logic [PRIO_W-1:0] entry_priority;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [TAG_W-1:0]   out_tag;
    logic [SIZE_W-1:0]  out_size;
    logic [PRIO_W-1:0]  out_priority;
    logic [COUNT_W-1:0] entry_count;
    logic [TOTAL_W-1:0] size_total;
  } out_item_t;

  // one stored job entry
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- rtl/core/stable_priority_queue_with_size_sum.sv -----
// Stable priority queue of job entries (tag, size, priority) with a running
// sum of held sizes. An enqueue places the entry behind every held entry of
// greater or equal priority, so equal priorities leave in arrival order; a
// dequeue returns the head entry. Every input item gives exactly one result
// item carrying the status, the dequeued entry (zero otherwise), the count of
// held entries and the size total after the operation. The entries live in a
// single one-read one-write RAM used as a ring with a moving head, so a
// dequeue passes from accept to result register through read, update and
// hand-over (ST_IDLE, ST_DEQ, ST_RESP). An enqueue walks from the tail
// towards the head, moving one entry back by one place per cycle until it
// meets an entry of greater or equal priority. Enqueue on a full queue and
// dequeue on an empty one go from ST_IDLE straight to ST_RESP. The RAM port
// sets the rate of one entry moved per cycle. One item is worked on at a
// time; a new item is taken while the previous result still waits on a
// stalled output. No clearing pass after reset is needed.
`default_nettype none
module stable_priority_queue_with_size_sum #(
  parameter int unsigned CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  spq_pkg::in_item_t    in_item_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spq_pkg::out_item_t   out_item_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CapWrap = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_LAST = 5'b00100,
    ST_DEQ  = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  logic [IW-1:0]              head_q, head_d;     // ring position of the queue head
  logic [IW-1:0]              walk_q, walk_d;     // logical index being read in the walk
  logic [CW-1:0]              count_q, count_d;
  logic [spq_pkg::SUM_W-1:0]  sum_q, sum_d;
  spq_pkg::entry_t            new_q, new_d;       // entry being inserted
  spq_pkg::out_item_t         res_q, res_d;       // finished result, waiting for the output stage
  spq_pkg::out_item_t         out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr, ram_raddr;
  spq_pkg::entry_t            ram_wdata, ram_rdata;

  logic                       in_accept;
  logic                       out_free;

  // logical queue position to ring address
  function automatic logic [IW-1:0] ring_addr(input logic [IW-1:0] base,
                                              input logic [IW-1:0] offs);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, offs};
    if (s >= CapWrap) begin
      s = s - CapWrap;
    end
    return s[IW-1:0];
  endfunction

  spq_ram #(
    .Width (spq_pkg::ENTRY_W),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    walk_d      = walk_q;
    count_d     = count_q;
    sum_d       = sum_q;
    new_d       = new_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_wdata   = new_q;
    ram_raddr   = head_q;

    // output stage drains when taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_d.out_tag      = '0;
          res_d.out_size     = '0;
          res_d.out_priority = '0;
          res_d.entry_count  = spq_pkg::COUNT_W'(count_q);
          res_d.size_total   = sum_q[spq_pkg::TOTAL_W-1:0];
          if (in_item_i.opcode == spq_pkg::OP_ENQ) begin
            if (count_q == CapCount) begin
              // full: entry dropped
              res_d.status = spq_pkg::STATUS_FULL;
              state_d      = ST_RESP;
            end else begin
              new_d.tag          = in_item_i.entry_tag;
              new_d.size         = in_item_i.entry_size;
              new_d.prio         = in_item_i.entry_priority;
              count_d            = count_q + 1'b1;
              sum_d              = sum_q + {{(spq_pkg::SUM_W - spq_pkg::SIZE_W){1'b0}},
                                            in_item_i.entry_size};
              res_d.status       = spq_pkg::STATUS_OK;
              res_d.entry_count  = spq_pkg::COUNT_W'(count_d);
              res_d.size_total   = sum_d[spq_pkg::TOTAL_W-1:0];
              if (count_q == '0) begin
                // empty queue: write straight at the head
                ram_we    = 1'b1;
                ram_waddr = head_q;
                ram_wdata = new_d;
                state_d   = ST_RESP;
              end else begin
                // start the walk at the tail
                walk_d    = IW'(count_q - 1'b1);
                ram_raddr = ring_addr(head_q, walk_d);
                state_d   = ST_WALK;
              end
            end
          end else begin
            if (count_q == '0) begin
              res_d.status = spq_pkg::STATUS_EMPTY;
              state_d      = ST_RESP;
            end else begin
              ram_raddr = head_q;
              state_d   = ST_DEQ;
            end
          end
        end
      end

      ST_WALK: begin
        // ram_rdata holds the entry at logical index walk_q
        ram_we    = 1'b1;
        ram_waddr = ring_addr(head_q, walk_q + 1'b1);
        if (ram_rdata.prio >= new_q.prio) begin
          ram_wdata = new_q;
          state_d   = ST_RESP;
        end else begin
          ram_wdata = ram_rdata;
          if (walk_q == '0) begin
            state_d = ST_LAST;
          end else begin
            walk_d    = walk_q - 1'b1;
            ram_raddr = ring_addr(head_q, walk_d);
          end
        end
      end

      ST_LAST: begin
        // every held entry ranks lower: new entry becomes the head
        ram_we    = 1'b1;
        ram_waddr = head_q;
        ram_wdata = new_q;
        state_d   = ST_RESP;
      end

      ST_DEQ: begin
        count_d            = count_q - 1'b1;
        sum_d              = sum_q - {{(spq_pkg::SUM_W - spq_pkg::SIZE_W){1'b0}},
                                      ram_rdata.size};
        head_d             = ring_addr(head_q, IW'(1));
        res_d.status       = spq_pkg::STATUS_OK;
        res_d.out_tag      = ram_rdata.tag;
        res_d.out_size     = ram_rdata.size;
        res_d.out_priority = ram_rdata.prio;
        res_d.entry_count  = spq_pkg::COUNT_W'(count_d);
        res_d.size_total   = sum_d[spq_pkg::TOTAL_W-1:0];
        state_d            = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      walk_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      walk_q      <= walk_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire

// ----- rtl/core/spq_ram.sv -----
`default_nettype none
module spq_ram #(
  parameter int unsigned Width = spq_pkg::ENTRY_W,
  parameter int unsigned Depth = spq_pkg::DEFAULT_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/spq_checker.sv -----
`default_nettype none
module spq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input spq_pkg::out_item_t out_item_o
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // items taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without an item taken");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == spq_pkg::STATUS_EMPTY |->
      out_item_o.entry_count == '0 && out_item_o.size_total == '0 &&
      out_item_o.out_tag == '0 && out_item_o.out_size == '0 &&
      out_item_o.out_priority == '0)
    else $error("empty status with non-empty report");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == spq_pkg::STATUS_FULL |->
      out_item_o.out_tag == '0 && out_item_o.out_size == '0 &&
      out_item_o.out_priority == '0)
    else $error("full status with entry payload");

endmodule

bind stable_priority_queue_with_size_sum spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire

// ----- tb/stable_priority_queue_with_size_sum_tb.sv -----
`timescale 1ns / 1ps
module stable_priority_queue_with_size_sum_tb;

  // queue depth under test and run bounds
  localparam int unsigned QUEUE_DEPTH   = spq_pkg::DEFAULT_CAPACITY;
  localparam int unsigned RUN_LIMIT     = 1_000_000;
  // longest enqueue walk plus hand-over, with some margin
  localparam int unsigned SETTLE_CYCLES = QUEUE_DEPTH + 8;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [spq_pkg::TAG_W-1:0]  TAG_MAX  = '1;
  localparam logic [spq_pkg::SIZE_W-1:0] SIZE_MAX = '1;
  localparam logic [spq_pkg::PRIO_W-1:0] PRIO_MAX = '1;

  // clock, reset and block inputs, all known from time zero
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  spq_pkg::in_item_t  in_item   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  spq_pkg::out_item_t out_item;

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off, counted down by the receiver process
  int hold_off_left  = 0;

  // shadow of the job queue: head at index 0, sorted by falling priority
  spq_pkg::entry_t           held_entries[$];
  logic [spq_pkg::SUM_W-1:0] held_size_sum = '0;
  // results still owed by the block, oldest first
  spq_pkg::out_item_t        pending_results[$];

  // run statistics
  int unsigned cycle_count         = 0;
  int unsigned sent_count          = 0;
  int unsigned checked_count       = 0;
  int unsigned mismatch_count      = 0;
  int unsigned enq_count           = 0;
  int unsigned deq_count           = 0;
  int unsigned full_count          = 0;
  int unsigned empty_count         = 0;
  int unsigned peak_depth          = 0;
  int unsigned input_stall_cycles  = 0;

  stable_priority_queue_with_size_sum #(
    .CAPACITY(QUEUE_DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_item_i  (in_item),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expected result of one job request, updating the shadow queue
  function automatic spq_pkg::out_item_t predict_queue_op(input spq_pkg::in_item_t req);
    spq_pkg::out_item_t res;
    spq_pkg::entry_t    ent;
    int                 pos;
    res        = '0;
    res.status = spq_pkg::STATUS_OK;
    if (req.opcode == spq_pkg::OP_ENQ) begin
      if (held_entries.size() >= QUEUE_DEPTH) begin
        // full queue drops the entry
        res.status = spq_pkg::STATUS_FULL;
        full_count++;
      end else begin
        ent.tag  = req.entry_tag;
        ent.size = req.entry_size;
        ent.prio = req.entry_priority;
        // behind every entry of greater or equal priority, so ties keep arrival order
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio >= req.entry_priority)
          pos++;
        held_entries.insert(pos, ent);
        held_size_sum = held_size_sum + spq_pkg::SUM_W'(req.entry_size);
        enq_count++;
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.status = spq_pkg::STATUS_EMPTY;
        empty_count++;
      end else begin
        ent              = held_entries.pop_front();
        res.out_tag      = ent.tag;
        res.out_size     = ent.size;
        res.out_priority = ent.prio;
        held_size_sum    = held_size_sum - spq_pkg::SUM_W'(ent.size);
        deq_count++;
      end
    end
    res.entry_count = spq_pkg::COUNT_W'(held_entries.size());
    res.size_total  = held_size_sum[spq_pkg::TOTAL_W-1:0];
    if (held_entries.size() > peak_depth) peak_depth = held_entries.size();
    return res;
  endfunction

  function automatic string fmt_result(input spq_pkg::out_item_t r);
    return $sformatf("status %0d tag %0d size %0d prio %0d count %0d total %0d",
                     r.status, r.out_tag, r.out_size, r.out_priority, r.entry_count,
                     r.size_total);
  endfunction

  // compare one accepted result item with the oldest expectation
  task automatic check_result(input spq_pkg::out_item_t got);
    spq_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("[%0t] result item with nothing expected: %s", $realtime, fmt_result(got));
      return;
    end
    want = pending_results.pop_front();
    checked_count++;
    if (got.status !== want.status || got.out_tag !== want.out_tag ||
        got.out_size !== want.out_size || got.out_priority !== want.out_priority ||
        got.entry_count !== want.entry_count || got.size_total !== want.size_total) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("[%0t] mismatch on result %0d", $realtime, checked_count);
        $display("  expected %s", fmt_result(want));
        $display("  actual   %s", fmt_result(got));
      end
    end
  endtask

  // output side: every accepted result item is checked; also count input back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_item);
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_stall     <= 1'b1;
      hold_off_left  = hold_off_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("watchdog expired after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("simulation failed");
    $finish;
  end

  // offer one item, with random idle cycles first; returns at the accepting edge
  task automatic send_request(input spq_pkg::in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_queue_op(req));
    sent_count++;
  endtask

  function automatic spq_pkg::in_item_t make_req(input spq_pkg::op_e op,
                                                 input logic [spq_pkg::TAG_W-1:0] tag,
                                                 input logic [spq_pkg::SIZE_W-1:0] size,
                                                 input logic [spq_pkg::PRIO_W-1:0] prio);
    spq_pkg::in_item_t r;
    r.opcode         = op;
    r.entry_tag      = tag;
    r.entry_size     = size;
    r.entry_priority = prio;
    return r;
  endfunction

  // random request; narrow priorities give many ties
  function automatic spq_pkg::in_item_t random_request(input int enq_pct,
                                                       input bit narrow_prio);
    spq_pkg::in_item_t r;
    r.opcode    = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
    r.entry_tag = spq_pkg::TAG_W'($urandom);
    case ($urandom_range(9))
      0:       r.entry_size = '0;
      1:       r.entry_size = SIZE_MAX;
      default: r.entry_size = spq_pkg::SIZE_W'($urandom);
    endcase
    case ($urandom_range(9))
      0:       r.entry_priority = '0;
      1:       r.entry_priority = PRIO_MAX;
      default: r.entry_priority = narrow_prio ? spq_pkg::PRIO_W'($urandom_range(3))
                                              : spq_pkg::PRIO_W'($urandom);
    endcase
    return r;
  endfunction

  // extremes of every field, ties at top, middle and bottom, empty dequeues
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // dequeue on empty queue, with noise in the ignored fields
    send_request(make_req(spq_pkg::OP_DEQ, TAG_MAX, SIZE_MAX, PRIO_MAX));
    send_request(make_req(spq_pkg::OP_ENQ, '0, '0, '0));
    send_request(make_req(spq_pkg::OP_ENQ, TAG_MAX, SIZE_MAX, PRIO_MAX));
    send_request(make_req(spq_pkg::OP_ENQ, 16'd1, 31'd5, PRIO_MAX));
    send_request(make_req(spq_pkg::OP_ENQ, 16'd2, 31'd7, '0));
    send_request(make_req(spq_pkg::OP_ENQ, 16'd3, 31'd9, 8'd128));
    send_request(make_req(spq_pkg::OP_ENQ, 16'd4, 31'd11, 8'd128));
    send_request(make_req(spq_pkg::OP_ENQ, 16'd5, 31'd13, 8'd127));
    // drain in priority order, ties in arrival order
    for (int i = 0; i < 7; i++) send_request(make_req(spq_pkg::OP_DEQ, '0, '0, '0));
    send_request(make_req(spq_pkg::OP_DEQ, '0, '0, '0));
    send_request(make_req(spq_pkg::OP_ENQ, 16'h5a5a, 31'h2aaa_aaaa, 8'h55));
    send_request(make_req(spq_pkg::OP_DEQ, 16'ha5a5, 31'h5555_5555, 8'haa));
  endtask

  // fill to capacity twice, overflow, then drain past empty
  task automatic test_full_and_empty();
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    // rising priority puts each entry at the head: longest walk, largest size total
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_request(make_req(spq_pkg::OP_ENQ, spq_pkg::TAG_W'(i), SIZE_MAX,
                            spq_pkg::PRIO_W'(i)));
    send_request(make_req(spq_pkg::OP_ENQ, TAG_MAX, SIZE_MAX, PRIO_MAX));
    send_request(make_req(spq_pkg::OP_ENQ, '0, '0, '0));
    for (int i = 0; i < QUEUE_DEPTH + 2; i++)
      send_request(make_req(spq_pkg::OP_DEQ, '0, '0, '0));
    // all one priority: must come out in arrival order
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_request(make_req(spq_pkg::OP_ENQ, spq_pkg::TAG_W'(16'h8000 + i),
                            spq_pkg::SIZE_W'($urandom), 8'd42));
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) send_request(random_request(0, 1'b1));
  endtask

  // random traffic in blocks that fill, hover or drain the queue
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    int enq_pct;
    bit narrow;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    enq_pct        = 50;
    narrow         = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(2))
          0:       enq_pct = 85;
          1:       enq_pct = 50;
          default: enq_pct = 20;
        endcase
        narrow = 1'($urandom_range(1));
      end
      send_request(random_request(enq_pct, narrow));
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 400;
    for (int i = 0; i < 24; i++) send_request(random_request(60, 1'b1));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_and_empty();
    test_random_traffic(430, 0, 0);
    test_random_traffic(430, 67, 0);
    test_random_traffic(430, 0, 67);
    test_random_traffic(430, 23, 23);
    test_output_hold_off();
    in_valid <= 1'b0;

    // let every owed result arrive, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked: %0d enqueued, %0d dequeued, %0d full, %0d empty",
             sent_count, checked_count, enq_count, deq_count, full_count, empty_count);
    $display("deepest queue %0d of %0d, input stalled %0d cycles, %0d mismatches, %0d cycles",
             peak_depth, QUEUE_DEPTH, input_stall_cycles, mismatch_count, cycle_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- stable_priority_queue_with_size_sum.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/stable_priority_queue_with_size_sum.sv
rtl/core/spq_checker.sv
tb/stable_priority_queue_with_size_sum_tb.sv
